// File: src/ida_pkg.sv
// Package: shared types and constants for the identifier allocator.
`timescale 1ns / 1ps

package ida_pkg;

    // Identifier geometry: each cell holds one word of each map
    localparam int ID_W      = 10;
    localparam int OFS_W     = ID_W / 2;
    localparam int CELL_W    = ID_W - OFS_W;
    localparam int WORD_W    = 1 << OFS_W;
    localparam int NUM_CELLS = 1 << CELL_W;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [OFS_W-1:0]  ofs_t;
    typedef logic [CELL_W-1:0] cell_idx_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam id_t ID_MAX = '1;

    // Operation codes
    typedef enum logic {
        OP_ALLOC  = 1'b0,
        OP_RETURN = 1'b1
    } op_e;

    // Register indexes
    typedef enum logic {
        REG_START_ID = 1'b0,
        REG_END_ID   = 1'b1
    } reg_idx_e;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_DONE
    } state_e;

    // Request and response items
    typedef struct packed {
        logic op;
        id_t  id;
    } req_item_t;

    typedef struct packed {
        id_t  granted_id;
        logic ok;
        logic can_allocate;
    } rsp_item_t;

    // Update command broadcast to every cell
    typedef struct packed {
        logic      clr_all;
        logic      set_en;
        logic      set_b;
        cell_idx_t set_cell;
        ofs_t      set_ofs;
        logic      clr_en;
        logic      clr_b;
        cell_idx_t clr_cell;
        ofs_t      clr_ofs;
    } cell_ctrl_t;

    // Lowest-set search result handed from cell to cell
    typedef struct packed {
        logic hit_a;
        id_t  idx_a;
        logic hit_b;
        id_t  idx_b;
    } search_t;

    // Offset of the lowest set bit of a word (zero if none)
    function automatic ofs_t lowest_bit(input word_t w);
        ofs_t r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = ofs_t'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: src/ida_cell.sv
// One cell: a word of each free map plus its stage of the lowest-set search.
`timescale 1ns / 1ps

module ida_cell
    import ida_pkg::*;
#(
    parameter cell_idx_t CELL_IDX = '0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  search_t    chain_in,
    output search_t    chain_out
);

    word_t word_a_reg, word_a_next;
    word_t word_b_reg, word_b_next;

    // Map update: clear-all, then set on return, clear on grant
    always_comb
    begin
        word_a_next = word_a_reg;
        word_b_next = word_b_reg;
        if (ctrl.clr_all)
        begin
            word_a_next = '0;
            word_b_next = '0;
        end
        else
        begin
            if (ctrl.set_en && ctrl.set_cell == CELL_IDX)
            begin
                if (ctrl.set_b)
                begin
                    word_b_next[ctrl.set_ofs] = 1'b1;
                end
                else
                begin
                    word_a_next[ctrl.set_ofs] = 1'b1;
                end
            end
            if (ctrl.clr_en && ctrl.clr_cell == CELL_IDX)
            begin
                if (ctrl.clr_b)
                begin
                    word_b_next[ctrl.clr_ofs] = 1'b0;
                end
                else
                begin
                    word_a_next[ctrl.clr_ofs] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_reg <= '0;
            word_b_reg <= '0;
        end
        else
        begin
            word_a_reg <= word_a_next;
            word_b_reg <= word_b_next;
        end
    end

    // Search stage: first non-empty cell claims the result
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.hit_a && (|word_a_reg))
        begin
            chain_out.hit_a = 1'b1;
            chain_out.idx_a = {CELL_IDX, lowest_bit(word_a_reg)};
        end
        if (!chain_in.hit_b && (|word_b_reg))
        begin
            chain_out.hit_b = 1'b1;
            chain_out.idx_b = {CELL_IDX, lowest_bit(word_b_reg)};
        end
    end

endmodule

// File: src/ida_chain.sv
// Row of cells holding both free maps, lowest cell first in the search chain.
`timescale 1ns / 1ps

module ida_chain
    import ida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    output search_t    result
);

    search_t links [NUM_CELLS+1];

    assign links[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        ida_cell #(
            .CELL_IDX (cell_idx_t'(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .chain_in  (links[i]),
            .chain_out (links[i+1])
        );
    end

    assign result = links[NUM_CELLS];

endmodule

// File: src/id_allocator_deferred_reuse.sv
// Top level: identifier allocator with fresh range and two swapping free maps.
// Item flow: op_reg and id_reg, then granted_reg and ok_reg, then rsp_reg. ST_WORK
// does the lowest-set search through the row of cells plus the map update; ST_DONE
// does the empty check on the new maps and takes the next item once rsp_reg is free.
// Reset clears both free maps at once in the cells, sets start_id 1 and end_id 1023.
// A register write clears the maps and restarts the fresh range.
`timescale 1ns / 1ps

module id_allocator_deferred_reuse
    import ida_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  id_t       cfg_data
);

    state_e state_reg, state_next;

    id_t  start_reg, start_next;
    id_t  end_reg, end_next;
    id_t  range_end_reg, range_end_next;
    id_t  last_fresh_reg, last_fresh_next;
    logic exhausted_reg, exhausted_next;
    logic give_b_reg, give_b_next;

    logic op_reg;
    id_t  id_reg;
    id_t  granted_reg, granted_next;
    logic ok_reg, ok_next;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_reg, rsp_next;

    cell_ctrl_t ctrl;
    search_t    found;

    logic req_accept;
    logic rsp_free;
    id_t  cfg_s, cfg_e;
    id_t  fresh_id;
    logic give_hit, ret_hit;
    id_t  give_idx, ret_idx;

    ida_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .result (found)
    );

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !(state_reg == ST_IDLE || (state_reg == ST_DONE && rsp_free));
    assign req_accept = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Register values as they stand after this cycle's write
    assign cfg_s = (cfg_we && cfg_index == REG_START_ID) ? cfg_data : start_reg;
    assign cfg_e = (cfg_we && cfg_index == REG_END_ID) ? cfg_data : end_reg;

    assign fresh_id = last_fresh_reg + id_t'(1);

    // Give and returned pools as seen through the swap flag
    assign give_hit = give_b_reg ? found.hit_b : found.hit_a;
    assign give_idx = give_b_reg ? found.idx_b : found.idx_a;
    assign ret_hit  = give_b_reg ? found.hit_a : found.hit_b;
    assign ret_idx  = give_b_reg ? found.idx_a : found.idx_b;

    // Sequencer, allocator state and map commands
    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        range_end_next  = range_end_reg;
        last_fresh_next = last_fresh_reg;
        exhausted_next  = exhausted_reg;
        give_b_next     = give_b_reg;
        granted_next    = granted_reg;
        ok_next         = ok_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ctrl            = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                granted_next = '0;
                ok_next      = 1'b0;
                if (op_reg == OP_RETURN)
                begin
                    ctrl.set_en   = 1'b1;
                    ctrl.set_b    = !give_b_reg;
                    ctrl.set_cell = id_reg[ID_W-1:OFS_W];
                    ctrl.set_ofs  = id_reg[OFS_W-1:0];
                    ok_next       = 1'b1;
                end
                else if (!exhausted_reg)
                begin
                    last_fresh_next = fresh_id;
                    exhausted_next  = (fresh_id >= range_end_reg);
                    granted_next    = fresh_id;
                    ok_next         = 1'b1;
                end
                else if (give_hit)
                begin
                    ctrl.clr_en   = 1'b1;
                    ctrl.clr_b    = give_b_reg;
                    ctrl.clr_cell = give_idx[ID_W-1:OFS_W];
                    ctrl.clr_ofs  = give_idx[OFS_W-1:0];
                    granted_next  = give_idx;
                    ok_next       = 1'b1;
                end
                else if (ret_hit)
                begin
                    // Give pool dry: swap roles and take from the other one
                    give_b_next   = !give_b_reg;
                    ctrl.clr_en   = 1'b1;
                    ctrl.clr_b    = !give_b_reg;
                    ctrl.clr_cell = ret_idx[ID_W-1:OFS_W];
                    ctrl.clr_ofs  = ret_idx[OFS_W-1:0];
                    granted_next  = ret_idx;
                    ok_next       = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.granted_id   = granted_reg;
                    rsp_next.ok           = ok_reg;
                    rsp_next.can_allocate =
                        !(exhausted_reg && !found.hit_a && !found.hit_b);
                    state_next = req_accept ? ST_WORK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write: store and reinitialize
        if (cfg_we)
        begin
            start_next     = cfg_s;
            end_next       = cfg_e;
            exhausted_next = 1'b0;
            give_b_next    = 1'b0;
            ctrl.clr_all   = 1'b1;
            if (cfg_s > cfg_e)
            begin
                range_end_next  = ID_MAX;
                last_fresh_next = '0;
            end
            else
            begin
                range_end_next  = cfg_e;
                last_fresh_next = cfg_s - id_t'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= id_t'(1);
            end_reg        <= ID_MAX;
            range_end_reg  <= ID_MAX;
            last_fresh_reg <= '0;
            exhausted_reg  <= 1'b0;
            give_b_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            range_end_reg  <= range_end_next;
            last_fresh_reg <= last_fresh_next;
            exhausted_reg  <= exhausted_next;
            give_b_reg     <= give_b_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg <= req.op;
            id_reg <= req.id;
        end
        granted_reg <= granted_next;
        ok_reg      <= ok_next;
        rsp_reg     <= rsp_next;
    end

endmodule
